[rtl/core/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and helpers for the base64 decoder
// Character mapping, pad code and the group record passed front to back.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Sextet code for '=' and any byte outside the alphabet
  localparam logic [6:0] PadSextet = 7'd64;

  // Group queue sizing
  localparam int unsigned GrpDepth = 4;
  localparam int unsigned GrpPtrW  = $clog2(GrpDepth);
  localparam int unsigned GrpCntW  = $clog2(GrpDepth + 1);

  // One closed group: up to three bytes, their count (1..3) and end flag
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            fin;
  } group_t;

  // Map one character to its sextet, pad for anything not in the alphabet
  function automatic logic [6:0] char_to_sextet(input logic [7:0] ch);
    logic [7:0] v;
    v = 8'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = ch - 8'd65;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = ch - 8'd71;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = ch + 8'd4;
    end else if (ch == 8'h2B) begin
      v = 8'd62;
    end else if (ch == 8'h2F) begin
      v = 8'd63;
    end else begin
      v = {1'b0, PadSextet};
    end
    return v[6:0];
  endfunction

endpackage

[rtl/core/b64d_front.sv]
// ----------------------------------------------------------------------------
// b64d_front: character intake and group assembly
// Maps characters to sextets, holds the open group and, when a group
// closes, forms its bytes and byte count and pushes them to the queue.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_i,
  input  logic       final_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output group_t     q_data_o
);

  logic [2:0][6:0] store_q;
  logic [1:0]      cnt_q, cnt_d;
  logic [6:0]      cur;
  logic [3:0][6:0] s;
  logic            accept;
  logic            close;
  logic [1:0]      nb;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cur        = char_to_sextet(char_i);
  assign close      = (cnt_q == 2'd3) || final_i;

  // Assemble the four group positions, missing ones are pads
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < 3 && 2'(k) < cnt_q) begin
        s[k] = store_q[k[1:0]];
      end else if (k < 4 && 3'(k) == {1'b0, cnt_q}) begin
        s[k] = cur;
      end else begin
        s[k] = PadSextet;
      end
    end
  end

  // Byte count of the closed group
  always_comb begin
    priority if (s[0] == PadSextet) begin
      nb = 2'd0;
    end else if (s[2] == PadSextet) begin
      nb = 2'd1;
    end else if (s[3] == PadSextet) begin
      nb = 2'd2;
    end else begin
      nb = 2'd3;
    end
  end

  // Byte formation, pads take part with their code value
  always_comb begin
    q_data_o.bytes[0] = {s[0][5:0], 2'b00} | {5'b0, s[1][6:4]};
    q_data_o.bytes[1] = {s[1][3:0], 4'b0000} | {3'b0, s[2][6:2]};
    q_data_o.bytes[2] = {s[2][1:0], 6'b0} | {1'b0, s[3]};
    q_data_o.nbytes   = nb;
    q_data_o.fin      = final_i;
  end

  // Groups that yield no byte are dropped here
  assign q_push_o = accept && close && (nb != 2'd0);

  // Position count
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = close ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Sextet store, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && !close) begin
      store_q[cnt_q] <= cur;
    end
  end

endmodule

[rtl/core/b64d_fifo.sv]
// ----------------------------------------------------------------------------
// b64d_fifo: short group queue
// Decouples group assembly from byte output; one push and one pop a cycle.
// ----------------------------------------------------------------------------
module b64d_fifo
  import b64d_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  group_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output group_t head_o
);

  group_t               mem_q [GrpDepth];
  logic [GrpPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [GrpCntW-1:0]   count_q;

  assign full_o  = (count_q == GrpCntW'(GrpDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == GrpPtrW'(GrpDepth - 1)) ? '0 : wr_ptr_q + GrpPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == GrpPtrW'(GrpDepth - 1)) ? '0 : rd_ptr_q + GrpPtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + GrpCntW'(1);
        2'b01:   count_q <= count_q - GrpCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/b64d_back.sv]
// ----------------------------------------------------------------------------
// b64d_back: byte sequencer
// Walks the head group of the queue and presents its bytes one by one.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  group_t     q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_o,
  output logic       group_last_o,
  output logic       stream_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       take;

  assign out_valid_o  = !q_empty_i;
  assign byte_o       = q_head_i.bytes[idx_q];
  assign group_last_o = (idx_q == q_head_i.nbytes - 2'd1);
  assign stream_end_o = q_head_i.fin;

  assign take    = out_valid_o && out_ready_i;
  assign q_pop_o = take && group_last_o;

  // Byte index within the head group
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = group_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

[rtl/core/base64_decoder.sv]
// ----------------------------------------------------------------------------
// base64_decoder: streaming base64 decoder
// One character in per transaction, decoded bytes out one per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character in tdata; tlast marks the final character
//   of the buffer. '=' and bytes outside the alphabet count as pad.
//   m_axis carries one decoded byte in tdata; tlast marks the last byte of
//   its group and tuser is set when the group was closed by a final char.
//   A group closes on its fourth character or on a final character and
//   yields 0 to 3 bytes; a group whose first character is pad yields none.
// Timing:
//   The input takes one character per cycle; s_axis_tready drops only while
//   the four-deep group queue between the two sides is full. A closed group
//   is queued when its closing character is accepted, and its first byte is
//   offered once it heads the queue; bytes then go out at one per cycle while
//   m_axis_tready is high, set by the single output port of the sequencer.
// Reset:
//   Clears the open group and empties the queue. A stalled receiver holds
//   the current byte steady and backs up the queue, then the input.
// ----------------------------------------------------------------------------
module base64_decoder
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tlast,   // final_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tlast,   // group_last
  output logic       m_axis_tuser    // [0] stream_end
);

  logic   q_push, q_full, q_pop, q_empty;
  group_t q_wdata, q_head;

  // Intake and group assembly
  b64d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .char_i     (s_axis_tdata),
    .final_i    (s_axis_tlast),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // Group queue
  b64d_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // Byte output
  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .byte_o       (m_axis_tdata),
    .group_last_o (m_axis_tlast),
    .stream_end_o (m_axis_tuser)
  );

endmodule
